[design/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TEXT = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [9:0]  COUNT_MAX     = 10'd1023;
    localparam logic [10:0] CAPACITY_RST  = 11'd260;
    localparam logic [15:0] ASCII_MAX     = 16'h007F;
    localparam logic [7:0]  CHAR_QUOTE    = 8'h22;
    localparam logic [7:0]  CHAR_BSLASH   = 8'h5C;
    localparam logic [7:0]  CHAR_SLASH    = 8'h2F;
    localparam logic [7:0]  CHAR_QMARK    = 8'h3F;
    localparam logic [7:0]  CHAR_NUL      = 8'h00;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  hex_count;
        logic [15:0] hex_accum;
        logic [9:0]  char_count;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] out_char;
        logic [9:0] stored_len;
    } t_result;

    localparam t_state STATE_RST = '{
        mode:       MODE_IDLE,
        hex_count:  2'd0,
        hex_accum:  16'd0,
        char_count: 10'd0
    };

    // returns {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/jsu_step.sv]
// ----------------------------------------------------------------------------
// jsu_step
// Next-state and result logic for one raw byte of a quoted string.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_step
    import jsu_pkg::*;
(
    input  wire logic [7:0]  i_byte,
    input  wire t_state      i_state,
    input  wire logic [10:0] i_capacity,
    output t_state           o_state,
    output t_result          o_result
);

    logic [4:0]  w_hex;
    logic [15:0] w_accum;
    logic [7:0]  w_char;
    logic        w_emit;
    logic        w_finish;
    logic [1:0]  w_kind;
    logic        w_room;
    logic [10:0] w_next_count;

    assign w_hex        = hex_value(i_byte);
    assign w_accum      = {i_state.hex_accum[11:0], w_hex[3:0]};
    assign w_next_count = {1'b0, i_state.char_count} + 11'd1;
    assign w_room       = (w_next_count < i_capacity) && (i_state.char_count != COUNT_MAX);

    always_comb begin
        w_emit   = 1'b0;
        w_finish = 1'b0;
        w_kind   = KIND_ERR;
        w_char   = i_byte;
        o_state  = i_state;
        case (i_state.mode)
            MODE_IDLE: begin
                if (i_byte == CHAR_QUOTE) begin
                    o_state.mode       = MODE_TEXT;
                    o_state.char_count = 10'd0;
                end else begin
                    w_finish = 1'b1;
                end
            end
            MODE_TEXT: begin
                if (i_byte == CHAR_QUOTE) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_END;
                end else if (i_byte == CHAR_NUL) begin
                    w_finish = 1'b1;
                end else if (i_byte == CHAR_BSLASH) begin
                    o_state.mode = MODE_ESC;
                end else begin
                    w_emit = 1'b1;
                end
            end
            MODE_ESC: begin
                case (i_byte)
                    CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: w_emit = 1'b1;
                    8'h62: begin w_emit = 1'b1; w_char = 8'h08; end
                    8'h66: begin w_emit = 1'b1; w_char = 8'h0C; end
                    8'h6E: begin w_emit = 1'b1; w_char = 8'h0A; end
                    8'h72: begin w_emit = 1'b1; w_char = 8'h0D; end
                    8'h74: begin w_emit = 1'b1; w_char = 8'h09; end
                    8'h75: begin
                        o_state.mode      = MODE_HEX;
                        o_state.hex_count = 2'd0;
                        o_state.hex_accum = 16'd0;
                    end
                    default: w_finish = 1'b1;
                endcase
            end
            default: begin
                if (!w_hex[4]) begin
                    w_finish = 1'b1;
                end else if (i_state.hex_count == 2'd3) begin
                    w_emit            = 1'b1;
                    w_char            = (w_accum <= ASCII_MAX) ? w_accum[7:0] : CHAR_QMARK;
                    o_state.hex_count = 2'd0;
                    o_state.hex_accum = 16'd0;
                end else begin
                    o_state.hex_accum = w_accum;
                    o_state.hex_count = i_state.hex_count + 2'd1;
                end
            end
        endcase

        o_result.valid      = 1'b0;
        o_result.kind       = KIND_CHAR;
        o_result.out_char   = 8'd0;
        o_result.stored_len = i_state.char_count;

        if (w_finish) begin
            o_state         = STATE_RST;
            o_result.valid  = 1'b1;
            o_result.kind   = w_kind;
        end else if (w_emit) begin
            o_state.mode = MODE_TEXT;
            if (w_room) begin
                o_state.char_count  = w_next_count[9:0];
                o_result.valid      = 1'b1;
                o_result.out_char   = w_char;
                o_result.stored_len = w_next_count[9:0];
            end
        end
    end

endmodule

`default_nettype wire

[design/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes a quoted JSON string one raw byte per clock, while results are taken,
// into characters, an end marker with the stored length, or an error.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload                           role
//  in       i_in_valid / o_in_ready    i_in_byte                         byte in
//  out      o_out_valid / i_out_ready  o_kind, o_out_char, o_stored_len  result out
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_capacity                    register write
//
//  One byte per clock sustained while results are taken; a byte passes the input
//  register, then the result register. A byte yields zero or one result.
//  Synchronous active-low reset: idle, capacity 260, both stages empty.
//  A stalled result holds the decoder; an empty input register still takes a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape
    import jsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_char,
    output logic [9:0]       o_stored_len,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_capacity
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    logic [10:0] r_capacity;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_out_char;
    logic [9:0]  r_stored_len;
    logic        w_advance;

    jsu_step u_step (
        .i_byte     (r_in_byte),
        .i_state    (r_state),
        .i_capacity (r_capacity),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
            r_capacity  <= CAPACITY_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid && n_result.valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
        if (w_advance && r_in_valid && n_result.valid) begin
            r_kind       <= n_result.kind;
            r_out_char   <= n_result.out_char;
            r_stored_len <= n_result.stored_len;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_char   = r_out_char;
    assign o_stored_len = r_stored_len;

endmodule

`default_nettype wire

[design/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescape block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_out_char,
    input wire logic [9:0] o_stored_len
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_char) && $stable(o_stored_len))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind == KIND_CHAR || o_kind == KIND_END || o_kind == KIND_ERR)
        else $error("illegal result kind");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_CHAR |-> o_out_char == 8'd0)
        else $error("non-character result carries a character");

    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_CHAR |-> o_stored_len != 10'd0)
        else $error("character result with zero length");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_out_char   (o_out_char),
    .o_stored_len (o_stored_len)
);

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_unescape: a short table of directed
// bytes, then random quoted strings (well-formed mostly, some broken, some
// noise) under several capacity settings, with bursty input, a stalling
// result side and one long result stall. Each result is checked against the
// directed row's literal or a cycle-free decoder model kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_result    res;
    } t_dir_row;

    localparam int N_DIR       = 29;
    localparam int PHASE_BYTES = 92;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_in_byte      = 8'h00;
    logic        i_out_ready    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [10:0] i_cfg_capacity = 11'd0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_char;
    logic [9:0]  o_stored_len;
    logic        o_cfg_ready;

    // decoder model state
    logic [1:0]  dec_mode    = MODE_IDLE;
    logic [1:0]  dec_hex_n   = 2'd0;
    logic [15:0] dec_hex_acc = 16'd0;
    logic [9:0]  dec_count   = 10'd0;
    logic [10:0] dec_cap     = CAPACITY_RST;

    t_result     decoded_q [$];
    logic [7:0]  frame [$];
    logic        row_typed = 1'b0;
    t_result     row_lit   = '0;

    int n_fail      = 0;
    int n_bytes     = 0;
    int n_caps      = 1;
    int n_seen [3]  = '{0, 0, 0};
    int burst_left  = 0;
    int rx_tick     = 0;
    int rx_hold     = 0;
    logic rx_held   = 1'b0;

    t_dir_row directed_rows [N_DIR] = '{
        {"x",         1'b1, 1'b1, KIND_ERR,  8'h00, 10'd0},
        {CHAR_NUL,    1'b1, 1'b1, KIND_ERR,  8'h00, 10'd0},
        {CHAR_QUOTE,  1'b1, 1'b0, KIND_CHAR, 8'h00, 10'd0},
        {8'h01,       1'b1, 1'b1, KIND_CHAR, 8'h01, 10'd1},
        {8'hFF,       1'b1, 1'b1, KIND_CHAR, 8'hFF, 10'd2},
        {CHAR_BSLASH, 1'b1, 1'b0, KIND_CHAR, 8'h00, 10'd0},
        {"t",         1'b0, 21'd0},
        {CHAR_BSLASH, 1'b0, 21'd0},
        {"u",         1'b0, 21'd0},
        {"0",         1'b0, 21'd0},
        {"0",         1'b0, 21'd0},
        {"7",         1'b0, 21'd0},
        {"F",         1'b0, 21'd0},
        {CHAR_BSLASH, 1'b0, 21'd0},
        {"u",         1'b0, 21'd0},
        {"a",         1'b0, 21'd0},
        {"B",         1'b0, 21'd0},
        {"9",         1'b0, 21'd0},
        {"f",         1'b0, 21'd0},
        {CHAR_QUOTE,  1'b1, 1'b1, KIND_END,  8'h00, 10'd5},
        {CHAR_QUOTE,  1'b0, 21'd0},
        {CHAR_NUL,    1'b1, 1'b1, KIND_ERR,  8'h00, 10'd0},
        {CHAR_QUOTE,  1'b0, 21'd0},
        {CHAR_BSLASH, 1'b0, 21'd0},
        {"q",         1'b1, 1'b1, KIND_ERR,  8'h00, 10'd0},
        {CHAR_QUOTE,  1'b0, 21'd0},
        {CHAR_BSLASH, 1'b0, 21'd0},
        {"u",         1'b0, 21'd0},
        {"g",         1'b1, 1'b1, KIND_ERR,  8'h00, 10'd0}
    };

    json_string_unescape u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_char     (o_out_char),
        .o_stored_len   (o_stored_len),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // {is_hex, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return {1'b1, b[3:0]};
        end
        if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            return {1'b1, b[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic t_result end_string(input logic [1:0] kind);
        t_result r;
        r            = '0;
        r.valid      = 1'b1;
        r.kind       = kind;
        r.stored_len = dec_count;
        dec_mode     = MODE_IDLE;
        dec_hex_n    = 2'd0;
        dec_hex_acc  = 16'd0;
        dec_count    = 10'd0;
        return r;
    endfunction

    function automatic t_result store_char(input logic [7:0] ch);
        t_result r;
        r        = '0;
        dec_mode = MODE_TEXT;
        if ({1'b0, dec_count} + 11'd1 < dec_cap && dec_count < COUNT_MAX) begin
            dec_count    = dec_count + 10'd1;
            r.valid      = 1'b1;
            r.kind       = KIND_CHAR;
            r.out_char   = ch;
            r.stored_len = dec_count;
        end
        return r;
    endfunction

    function automatic t_result unescape_byte(input logic [7:0] b);
        t_result    r;
        logic [4:0] hx;
        r = '0;
        case (dec_mode)
            MODE_IDLE: begin
                if (b == CHAR_QUOTE) begin
                    dec_mode  = MODE_TEXT;
                    dec_count = 10'd0;
                end else begin
                    r = end_string(KIND_ERR);
                end
            end
            MODE_TEXT: begin
                if (b == CHAR_QUOTE) begin
                    r = end_string(KIND_END);
                end else if (b == CHAR_NUL) begin
                    r = end_string(KIND_ERR);
                end else if (b == CHAR_BSLASH) begin
                    dec_mode = MODE_ESC;
                end else begin
                    r = store_char(b);
                end
            end
            MODE_ESC: begin
                case (b)
                    CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: r = store_char(b);
                    "b": r = store_char(8'h08);
                    "f": r = store_char(8'h0C);
                    "n": r = store_char(8'h0A);
                    "r": r = store_char(8'h0D);
                    "t": r = store_char(8'h09);
                    "u": begin
                        dec_mode    = MODE_HEX;
                        dec_hex_n   = 2'd0;
                        dec_hex_acc = 16'd0;
                    end
                    default: r = end_string(KIND_ERR);
                endcase
            end
            default: begin
                hx = hex_nibble(b);
                if (!hx[4]) begin
                    r = end_string(KIND_ERR);
                end else begin
                    dec_hex_acc = {dec_hex_acc[11:0], hx[3:0]};
                    if (dec_hex_n == 2'd3) begin
                        r = store_char(dec_hex_acc <= ASCII_MAX ? dec_hex_acc[7:0]
                                                                : CHAR_QMARK);
                        dec_hex_n   = 2'd0;
                        dec_hex_acc = 16'd0;
                    end else begin
                        dec_hex_n = dec_hex_n + 2'd1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // check results, then predict for the request taken at this edge
    always @(posedge i_clk) begin
        t_result want;
        t_result calc;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: kind %0d char %02h len %0d",
                           o_kind, o_out_char, o_stored_len);
                    n_fail++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        n_fail++;
                    end
                    if (o_out_char !== want.out_char) begin
                        $error("out_char: expected %02h, got %02h",
                               want.out_char, o_out_char);
                        n_fail++;
                    end
                    if (o_stored_len !== want.stored_len) begin
                        $error("stored_len: expected %0d, got %0d",
                               want.stored_len, o_stored_len);
                        n_fail++;
                    end
                    n_seen[want.kind]++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                calc = unescape_byte(i_in_byte);
                if (row_typed) begin
                    calc = row_lit;
                end
                if (calc.valid) begin
                    decoded_q.push_back(calc);
                end
                n_bytes++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                dec_cap = i_cfg_capacity;
            end
        end
    end

    // result side: rotating stall patterns plus one long hold
    always @(negedge i_clk) begin
        rx_tick++;
        if (!rx_held && n_bytes >= 300) begin
            rx_held = 1'b1;
            rx_hold = 90;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_tick >> 7) & 3)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ((rx_tick & 4) != 0);
            endcase
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                i_in_byte  <= 8'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result lit);
        pace();
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        row_typed  <= typed;
        row_lit    <= lit;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame[j]) begin
            send_byte(frame[j], 1'b0, '0);
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CHAR_QUOTE || b == CHAR_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return {4'h3, nib};
        end
        return {($urandom_range(0, 1) == 1) ? 4'h6 : 4'h4, nib - 4'd9};
    endfunction

    task automatic send_string();
        logic [7:0]  escs [8];
        logic [7:0]  b;
        logic [15:0] cp;
        int          len;
        int          flaw;
        int          pick;
        int          k;
        int          h;
        escs = '{CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, "b", "f", "n", "r", "t"};
        frame.delete();
        flaw = ($urandom_range(0, 99) < 18) ? $urandom_range(1, 5) : 0;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if (flaw == 1) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE);
            frame.push_back(b);
            len = 0;
        end else begin
            frame.push_back(CHAR_QUOTE);
        end
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                frame.push_back(plain_byte());
            end else if (pick < 80) begin
                frame.push_back(CHAR_BSLASH);
                frame.push_back(escs[$urandom_range(0, 7)]);
            end else begin
                cp = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 127))
                                                  : 16'($urandom_range(0, 65535));
                frame.push_back(CHAR_BSLASH);
                frame.push_back("u");
                for (h = 3; h >= 0; h--) begin
                    frame.push_back(hex_char(cp[h*4 +: 4]));
                end
            end
        end
        case (flaw)
            0: frame.push_back(CHAR_QUOTE);
            2: frame.push_back(CHAR_NUL);
            3: begin
                do b = 8'($urandom_range(0, 255));
                while (b == "u" || b inside {escs});
                frame.push_back(CHAR_BSLASH);
                frame.push_back(b);
            end
            4: begin
                frame.push_back(CHAR_BSLASH);
                frame.push_back("u");
                repeat ($urandom_range(0, 3))
                    frame.push_back(hex_char(4'($urandom_range(0, 15))));
                do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) != 5'd0);
                frame.push_back(b);
            end
            5: repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        send_frame();
    endtask

    task automatic run_phase();
        int start;
        start = n_bytes;
        while (n_bytes - start < PHASE_BYTES) begin
            send_string();
        end
    endtask

    // leave the decoder idle and the pipeline empty
    task automatic close_phase();
        if (dec_mode != MODE_IDLE) begin
            send_byte(CHAR_NUL, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [10:0] c);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_caps++;
    endtask

    initial begin
        logic [10:0] cap_plan [9];
        int          i;
        cap_plan = '{11'd0, 11'd1, 11'd2, 11'd5, 11'd13, 11'd1024, 11'd1025,
                     11'd2047, 11'd0};
        cap_plan[8] = 11'($urandom_range(3, 2046));
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < N_DIR; i++) begin
            send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
        end
        run_phase();

        for (i = 0; i < 9; i++) begin
            close_phase();
            write_cap(cap_plan[i]);
            run_phase();
        end
        close_phase();
        repeat (6) @(negedge i_clk);

        $display("summary: %0d bytes over %0d capacity settings (0 to 2047)",
                 n_bytes, n_caps);
        $display("summary: checked %0d chars, %0d string ends, %0d errors",
                 n_seen[0], n_seen[1], n_seen[2]);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[json_string_unescape.f]
design/jsu_pkg.sv
design/jsu_step.sv
design/json_string_unescape.sv
design/jsu_checker.sv
tb/sv/tb.sv
